>>> sv/integer_decimal_formatter_core_defines.svh
// Assertion macros for the decimal formatter.
`ifndef INTEGER_DECIMAL_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_DECIMAL_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define IDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDF_ASSERT(lbl, prop, msg)
`define IDF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/idf_pkg.sv
`timescale 1ns / 1ps

package idf_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int VAL_W      = 64;
  localparam int CNT_W      = 7;

  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;

  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             wide;
    logic             sign_on;
    logic [6:0]       sign_ch;
    logic             zfill;
    logic             left;
    logic [CNT_W-1:0] prec;
    logic [CNT_W-1:0] width;
  } desc_t;

endpackage

>>> sv/idf_if.sv
`timescale 1ns / 1ps

interface idf_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic              arg_is_wide;
  logic [63:0]       value;
  logic [5:0]        min_width;
  logic signed [6:0] precision;
  logic              left_justify;
  logic              force_plus;
  logic              space_sign;
  logic              zero_pad;

  modport source (
    output valid, operation, arg_is_wide, value, min_width, precision,
           left_justify, force_plus, space_sign, zero_pad,
    input  ready
  );
  modport sink (
    input  valid, operation, arg_is_wide, value, min_width, precision,
           left_justify, force_plus, space_sign, zero_pad,
    output ready
  );
endinterface

interface idf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       last_char;

  modport source (
    output valid, out_char, char_valid, last_char,
    input  ready
  );
  modport sink (
    input  valid, out_char, char_valid, last_char,
    output ready
  );
endinterface

>>> sv/idf_front.sv
`timescale 1ns / 1ps

module idf_front #(
  parameter int MAX_WIDTH = 48
) (
  idf_in_if.sink          din,
  input  logic            full,
  output logic            push,
  output idf_pkg::desc_t  push_desc
);

  localparam logic [idf_pkg::CNT_W-1:0] PREC_MAX  = idf_pkg::CNT_W'(MAX_WIDTH - 1);
  localparam logic [idf_pkg::CNT_W-1:0] WIDTH_MAX = idf_pkg::CNT_W'(MAX_WIDTH);

  logic [31:0]              lo;
  logic                     neg_w;
  logic                     neg_n;
  logic                     neg;
  logic                     prec_given;
  logic [idf_pkg::CNT_W-1:0] prec_raw;
  logic [idf_pkg::CNT_W-1:0] width_raw;

  assign din.ready = !full;
  assign push      = din.valid && !full;

  always_comb begin
    lo         = din.value[31:0];
    neg_w      = din.operation && din.value[63];
    neg_n      = din.operation && lo[31];
    neg        = din.arg_is_wide ? neg_w : neg_n;
    prec_given = !din.precision[6];
    prec_raw   = $unsigned(din.precision);
    width_raw  = {1'b0, din.min_width};

    if (din.arg_is_wide) begin
      push_desc.mag = neg_w ? (64'd0 - din.value) : din.value;
    end else begin
      push_desc.mag = {32'd0, (neg_n ? (32'd0 - lo) : lo)};
    end
    push_desc.wide    = din.arg_is_wide;
    push_desc.sign_on = neg || din.force_plus || din.space_sign;
    if (neg) begin
      push_desc.sign_ch = idf_pkg::CH_MINUS;
    end else if (din.force_plus) begin
      push_desc.sign_ch = idf_pkg::CH_PLUS;
    end else begin
      push_desc.sign_ch = idf_pkg::CH_SPACE;
    end
    push_desc.zfill = din.zero_pad && !din.left_justify && !prec_given;
    push_desc.left  = din.left_justify;
    if (!prec_given) begin
      push_desc.prec = idf_pkg::CNT_W'(1);
    end else if (prec_raw > PREC_MAX) begin
      push_desc.prec = PREC_MAX;
    end else begin
      push_desc.prec = prec_raw;
    end
    push_desc.width = (width_raw > WIDTH_MAX) ? WIDTH_MAX : width_raw;
  end

endmodule

>>> sv/idf_fifo.sv
`timescale 1ns / 1ps

module idf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  idf_pkg::desc_t  push_desc,
  output logic            full,
  input  logic            pop,
  output idf_pkg::desc_t  pop_desc,
  output logic            empty
);

  idf_pkg::desc_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_desc = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/idf_back.sv
`timescale 1ns / 1ps
`include "integer_decimal_formatter_core_defines.svh"

module idf_back #(
  parameter int MAX_WIDTH = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  idf_pkg::desc_t  desc,
  output logic            pop,
  idf_out_if.source       dout
);

  localparam int CW = idf_pkg::CNT_W;
  localparam logic [CW-1:0] TOTAL_MAX = CW'(MAX_WIDTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_COUNT = 6'b000100,
    S_SIZE  = 6'b001000,
    S_PLAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [idf_pkg::VAL_W-1:0]   sh;
  logic [idf_pkg::BCD_W-1:0]   bcd;
  logic [idf_pkg::BCD_W-1:0]   bcd_adj;
  logic [5:0]                  iter;
  logic [4:0]                  ndig;
  logic [4:0]                  ndig_next;
  logic                        sign_on;
  logic [6:0]                  sign_ch;
  logic                        zfill;
  logic                        left;
  logic [CW-1:0]               prec;
  logic [CW-1:0]               width;
  logic [CW-1:0]               zext;
  logic [CW-1:0]               body;
  logic [CW-1:0]               b1;
  logic [CW-1:0]               b2;
  logic [CW-1:0]               b3;
  logic [CW-1:0]               b4;
  logic [CW-1:0]               total;
  logic [CW-1:0]               pos;
  logic [CW-1:0]               nd7;
  logic [CW-1:0]               pad;
  logic [CW-1:0]               b1_next;
  logic [CW-1:0]               b2_next;
  logic [CW-1:0]               b3_next;
  logic [CW-1:0]               b4_next;
  logic [CW-1:0]               total_next;
  logic [CW-1:0]               dig_off;
  logic [4:0]                  dig_idx;
  logic [3:0]                  dig_sel;
  logic                        load_ok;
  logic                        last_next;
  logic [6:0]                  char_next;
  logic                        out_valid;
  logic [6:0]                  out_char;
  logic                        char_valid;
  logic                        last_char;

  assign pop     = (state == S_IDLE) && !empty;
  assign load_ok = !out_valid || dout.ready;
  assign nd7     = {2'b00, ndig};

  assign dout.valid      = out_valid;
  assign dout.out_char   = out_char;
  assign dout.char_valid = char_valid;
  assign dout.last_char  = last_char;

  always_comb begin
    for (int i = 0; i < idf_pkg::MAX_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    ndig_next = 5'd0;
    for (int i = 0; i < idf_pkg::MAX_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        ndig_next = 5'(i + 1);
      end
    end
  end

  always_comb begin
    pad        = (width > body) ? (width - body) : '0;
    b1_next    = (!zfill && !left) ? pad : '0;
    b2_next    = b1_next + {{(CW-1){1'b0}}, sign_on};
    b3_next    = b2_next + zext + (zfill ? pad : '0);
    b4_next    = b3_next + nd7;
    total_next = b4_next + (left ? pad : '0);
  end

  always_comb begin
    dig_off = b4 - CW'(1) - pos;
    dig_idx = dig_off[4:0];
    dig_sel = 4'd0;
    for (int i = 0; i < idf_pkg::MAX_DIGITS; i++) begin
      if (dig_idx == 5'(i)) begin
        dig_sel = bcd[i*4 +: 4];
      end
    end
    if (pos < b1) begin
      char_next = idf_pkg::CH_SPACE;
    end else if (pos < b2) begin
      char_next = sign_ch;
    end else if (pos < b3) begin
      char_next = idf_pkg::CH_ZERO;
    end else if (pos < b4) begin
      char_next = idf_pkg::CH_ZERO | {3'b000, dig_sel};
    end else begin
      char_next = idf_pkg::CH_SPACE;
    end
    last_next = (total == '0) || (pos == total - CW'(1));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!empty) state_next = S_CONV;
      S_CONV:  if (iter == 6'd0) state_next = S_COUNT;
      S_COUNT: state_next = S_SIZE;
      S_SIZE:  state_next = S_PLAN;
      S_PLAN:  state_next = S_EMIT;
      S_EMIT:  if (load_ok && last_next) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sh      <= desc.wide ? desc.mag : {desc.mag[31:0], 32'd0};
        bcd     <= '0;
        iter    <= desc.wide ? 6'd63 : 6'd31;
        sign_on <= desc.sign_on;
        sign_ch <= desc.sign_ch;
        zfill   <= desc.zfill;
        left    <= desc.left;
        prec    <= desc.prec;
        width   <= desc.width;
      end
      S_CONV: begin
        bcd  <= {bcd_adj[idf_pkg::BCD_W-2:0], sh[idf_pkg::VAL_W-1]};
        sh   <= {sh[idf_pkg::VAL_W-2:0], 1'b0};
        iter <= iter - 6'd1;
      end
      S_COUNT: begin
        ndig <= ndig_next;
      end
      S_SIZE: begin
        zext <= (prec > nd7) ? (prec - nd7) : '0;
        body <= {{(CW-1){1'b0}}, sign_on} + ((prec > nd7) ? prec : nd7);
      end
      S_PLAN: begin
        b1    <= b1_next;
        b2    <= b2_next;
        b3    <= b3_next;
        b4    <= b4_next;
        total <= total_next;
        pos   <= '0;
      end
      S_EMIT: begin
        if (load_ok) begin
          pos <= pos + CW'(1);
        end
      end
      default: begin
        pos <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && load_ok) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && load_ok) begin
      out_char   <= (total == '0) ? idf_pkg::CH_NUL : char_next;
      char_valid <= total != '0;
      last_char  <= last_next;
    end
  end

  `IDF_ASSERT(a_pop_idle, pop |-> state == S_IDLE, "fifo pop outside idle")
  `IDF_ASSERT(a_conv_done, (state == S_CONV) && (iter == 6'd0) |=> state == S_COUNT, "conversion overran")
  `IDF_ASSERT(a_ndig_max, state == S_SIZE |-> ndig <= 5'(idf_pkg::MAX_DIGITS), "digit count out of range")
  `IDF_ASSERT(a_total_max, state == S_EMIT |-> total <= TOTAL_MAX, "line longer than max width")
  `IDF_ASSERT(a_last_ends, (state == S_EMIT) && load_ok && last_next |=> state == S_IDLE, "last word did not end the number")

endmodule

>>> sv/integer_decimal_formatter_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// din      in   operation arg_is_wide value min_width precision
//               left_justify force_plus space_sign zero_pad
// dout     out  out_char char_valid last_char
//
// Per number: a fetch from the queue, the shift-add-3 digit loop over 32 (narrow)
// or 64 (wide) magnitude bits, the count, size and plan setup states, then one
// word per cycle while dout is not stalled, for n words (n = 1 for an empty result).
// The front takes new numbers into a 2-entry queue while the back works.
// Reset (rst, synchronous) empties the queue and the output register.
// A stall on dout holds the back; din stalls only when the queue is full.

module integer_decimal_formatter_core #(
  parameter int MAX_WIDTH = 48
) (
  input  logic       clk,
  input  logic       rst,
  idf_in_if.sink     din,
  idf_out_if.source  dout
);

  idf_pkg::desc_t push_desc;
  idf_pkg::desc_t pop_desc;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  idf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .din       (din),
    .full      (full),
    .push      (push),
    .push_desc (push_desc)
  );

  idf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty)
  );

  idf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .desc  (pop_desc),
    .pop   (pop),
    .dout  (dout)
  );

endmodule
